/* rtl/core/icsum_pkg.sv */
// ----------------------------------------------------------------------------
// icsum_pkg
// Shared widths, command codes and protocol numbers for the Internet checksum
// block.
// ----------------------------------------------------------------------------
package icsum_pkg;

    localparam int unsigned CMD_W       = 2;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned IP_W        = 32;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned COUNT_W     = 16;
    // Eight 16-bit words summed without folding need three extra bits.
    localparam int unsigned RAW_W       = WORD_W + 3;

    localparam int unsigned S_TDATA_W   = 40;
    localparam int unsigned M_TDATA_W   = 16;

    localparam int unsigned DEF_MAX_PACKET_BYTES = 1500;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_IP  = 2'd0;
    localparam t_cmd CMD_UDP = 2'd1;
    localparam t_cmd CMD_TCP = 2'd2;

    localparam logic [WORD_W-1:0] PROTO_UDP = 16'd17;
    localparam logic [WORD_W-1:0] PROTO_TCP = 16'd6;

endpackage

/* rtl/core/internet_checksum_pseudo_header_top.sv */
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header_top
// Streaming one's-complement Internet checksum with optional IPv4
// pseudo-header for UDP and TCP.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle, except that a byte marked tlast
// waits while the output register holds a checksum not yet taken, and returns
// one 16-bit checksum per packet. Bytes pass through an input register, then
// a single stage that either pairs them into a 16-bit word and adds it to the
// running sum, or, on the last byte, adds the pending word and, for UDP and
// TCP, the pseudo-header words, and folds the carries into the output
// register. That one adder stage sets the rate of one byte per cycle outside
// that wait. The command in tuser and the remote address in tdata are used
// only on the last byte of a packet. Bytes beyond MAX_PACKET_BYTES are dropped
// from the sum and the count, but their tlast still closes the packet. The
// local address register may be written only while no packet is in flight.
module internet_checksum_pseudo_header_top #(
    parameter int unsigned MAX_PACKET_BYTES = icsum_pkg::DEF_MAX_PACKET_BYTES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [icsum_pkg::IP_W-1:0]      i_cfg_data,     // local_ip

    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [icsum_pkg::S_TDATA_W-1:0] i_s_tdata,      // data_byte[7:0], remote_ip[39:8]
    input  logic [icsum_pkg::CMD_W-1:0]     i_s_tuser,      // command[1:0]
    input  logic                            i_s_tlast,

    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [icsum_pkg::M_TDATA_W-1:0] o_m_tdata       // checksum[15:0]
);

    localparam int unsigned WW = icsum_pkg::WORD_W;
    localparam int unsigned RW = icsum_pkg::RAW_W;
    localparam int unsigned CW = icsum_pkg::COUNT_W;
    localparam int unsigned BW = icsum_pkg::BYTE_W;
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PACKET_BYTES);

    // Configuration
    logic [icsum_pkg::IP_W-1:0] r_local_ip;

    // Input register
    logic                        r_s1_vld;
    logic [BW-1:0]               r_s1_byte;
    logic [icsum_pkg::IP_W-1:0]  r_s1_remote;
    icsum_pkg::t_cmd             r_s1_cmd;
    logic                        r_s1_last;

    // Packet state
    logic [WW-1:0] r_sum,  n_sum;
    logic [CW-1:0] r_count, n_count;
    logic [BW-1:0] r_held, n_held;
    logic          r_odd,  n_odd;

    // Output register
    logic          r_out_vld;
    logic [WW-1:0] r_out_sum;

    logic          out_free;
    logic          s1_adv;
    logic          counted;
    logic [WW:0]   pair_sum;
    logic [WW-1:0] pair_fold;
    logic [WW-1:0] tail_word;
    logic [CW-1:0] upd_count;
    logic          pseudo_en;
    logic [WW-1:0] proto;
    logic [RW-1:0] raw_sum;
    logic [WW:0]   fold1;
    logic [WW-1:0] fold2;

    assign o_cfg_ready = 1'b1;

    assign out_free   = !r_out_vld || i_m_tready;
    // A byte that is not last never needs the output register.
    assign s1_adv     = r_s1_vld && (!r_s1_last || out_free);
    assign o_s_tready = !r_s1_vld || s1_adv;

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_sum;

    always_comb begin
        counted   = r_count < MAX_COUNT;
        upd_count = counted ? r_count + CW'(1) : r_count;

        pair_sum  = {1'b0, r_sum} + {1'b0, r_held, r_s1_byte};
        pair_fold = pair_sum[WW-1:0] + WW'(pair_sum[WW]);

        // The word still open at the end of the packet, padded with zero.
        if (counted) begin
            tail_word = r_odd ? {r_held, r_s1_byte} : {r_s1_byte, 8'h00};
        end else begin
            tail_word = r_odd ? {r_held, 8'h00} : '0;
        end

        pseudo_en = (r_s1_cmd == icsum_pkg::CMD_UDP) || (r_s1_cmd == icsum_pkg::CMD_TCP);
        proto     = (r_s1_cmd == icsum_pkg::CMD_UDP) ? icsum_pkg::PROTO_UDP
                                                     : icsum_pkg::PROTO_TCP;

        // Folding once at the end gives the same result as folding per add.
        raw_sum = RW'(r_sum) + RW'(tail_word);
        if (pseudo_en) begin
            raw_sum = raw_sum
                    + RW'(r_local_ip[31:16]) + RW'(r_local_ip[15:0])
                    + RW'(r_s1_remote[31:16]) + RW'(r_s1_remote[15:0])
                    + RW'(upd_count) + RW'(proto);
        end
        fold1 = (WW+1)'(raw_sum[WW-1:0]) + (WW+1)'(raw_sum[RW-1:WW]);
        fold2 = fold1[WW-1:0] + WW'(fold1[WW]);

        n_sum   = r_sum;
        n_count = r_count;
        n_held  = r_held;
        n_odd   = r_odd;
        if (r_s1_last) begin
            n_sum   = '0;
            n_count = '0;
            n_held  = '0;
            n_odd   = 1'b0;
        end else if (counted) begin
            n_count = upd_count;
            if (r_odd) begin
                n_sum  = pair_fold;
                n_held = '0;
                n_odd  = 1'b0;
            end else begin
                n_held = r_s1_byte;
                n_odd  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_local_ip <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_s1_byte   <= i_s_tdata[7:0];
            r_s1_remote <= i_s_tdata[39:8];
            r_s1_cmd    <= i_s_tuser;
            r_s1_last   <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_held  <= '0;
            r_odd   <= 1'b0;
        end else if (s1_adv) begin
            r_sum   <= n_sum;
            r_count <= n_count;
            r_held  <= n_held;
            r_odd   <= n_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            r_out_sum <= ~fold2;
        end
    end

    // Every counted byte toggles the pairing flag, so it tracks the count parity.
    a_odd_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_odd == r_count[0])
        else $error("pairing flag out of step with byte count");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_COUNT)
        else $error("byte count beyond packet limit");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> (r_count == '0 && !r_odd && r_sum == '0))
        else $error("packet state not cleared after last byte");

    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> r_out_vld)
        else $error("no checksum after last byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_m_tready) |-> !(s1_adv && r_s1_last))
        else $error("pending checksum overwritten");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming Internet checksum block.
// Packets of random length and content are streamed in with random gaps and
// output back-pressure, under several local addresses. A scoreboard keeps its
// own running one's-complement sum per packet and compares every checksum
// the block returns against the oldest one it has predicted.
// ----------------------------------------------------------------------------
module tb_top;

    import icsum_pkg::*;

    // The command code that has no name in the package acts like an IP header.
    localparam t_cmd CMD_RSVD = 2'd3;
    localparam int unsigned PKT_LIMIT = DEF_MAX_PACKET_BYTES;

    class icsum_scoreboard;
        logic [IP_W-1:0]    local_ip;
        logic [WORD_W-1:0]  partial_sum;
        logic [COUNT_W-1:0] byte_cnt;
        logic [BYTE_W-1:0]  high_byte;
        bit                 high_valid;
        logic [WORD_W-1:0]  expected_sums[$];
        int                 errors;

        function new();
            local_ip = '0;
            errors   = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            partial_sum = '0;
            byte_cnt    = '0;
            high_byte   = '0;
            high_valid  = 0;
        endfunction

        // Operands never exceed 16 bits, so a single end-around carry folds it.
        function logic [WORD_W-1:0] ones_add(logic [WORD_W-1:0] a, logic [WORD_W-1:0] w);
            logic [WORD_W:0] s;
            s = {1'b0, a} + {1'b0, w};
            return s[WORD_W-1:0] + WORD_W'(s[WORD_W]);
        endfunction

        function void note_input(t_cmd cmd, logic [BYTE_W-1:0] b, logic [IP_W-1:0] remote,
                                 bit last);
            logic [WORD_W-1:0] s;
            if (byte_cnt < COUNT_W'(PKT_LIMIT)) begin
                byte_cnt = byte_cnt + COUNT_W'(1);
                if (high_valid) begin
                    partial_sum = ones_add(partial_sum, {high_byte, b});
                    high_byte   = '0;
                    high_valid  = 0;
                end else begin
                    high_byte  = b;
                    high_valid = 1;
                end
            end
            if (!last) return;
            s = partial_sum;
            if (high_valid) s = ones_add(s, {high_byte, 8'h00});
            if (cmd == CMD_UDP || cmd == CMD_TCP) begin
                s = ones_add(s, local_ip[31:16]);
                s = ones_add(s, local_ip[15:0]);
                s = ones_add(s, remote[31:16]);
                s = ones_add(s, remote[15:0]);
                s = ones_add(s, byte_cnt);
                s = ones_add(s, (cmd == CMD_UDP) ? PROTO_UDP : PROTO_TCP);
            end
            expected_sums.push_back(~s);
            clear_packet();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [WORD_W-1:0] got);
            logic [WORD_W-1:0] want;
            if (expected_sums.size() == 0) begin
                report($sformatf("unexpected checksum %h", got));
                return;
            end
            want = expected_sums.pop_front();
            if (got !== want)
                report($sformatf("checksum %h, expected %h", got, want));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [IP_W-1:0]      i_cfg_data;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic [CMD_W-1:0]     i_s_tuser;
    logic                 i_s_tlast;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;

    icsum_scoreboard sb = new();
    bit idle_on;
    bit hold_rx;
    int bytes_sent;

    internet_checksum_pseudo_header_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (hold_rx)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= !(idle_on && $urandom_range(99) < 25);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    // Valid stays high from one byte to the next unless a gap is drawn.
    task automatic send_byte(t_cmd cmd, logic [BYTE_W-1:0] b, logic [IP_W-1:0] remote,
                             bit last);
        @(negedge i_clk);
        while (idle_on && $urandom_range(99) < 25) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {remote, b};
        i_s_tuser  = cmd;
        i_s_tlast  = last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(cmd, b, remote, last);
        bytes_sent++;
    endtask

    // Bytes go out from the top of the vector down.
    task automatic send_frame(t_cmd cmd, logic [IP_W-1:0] remote, int len,
                              logic [63:0] bytes);
        for (int k = 0; k < len; k++)
            send_byte(cmd, bytes[63 - 8*k -: 8], remote, k == len - 1);
    endtask

    task automatic send_random_packets(int n_bytes, int min_len, int max_len);
        int len;
        logic [BYTE_W-1:0] b;
        bytes_sent = 0;
        while (bytes_sent < n_bytes) begin
            len = $urandom_range(max_len, min_len);
            for (int k = 0; k < len; k++) begin
                // Runs of all-ones bytes force carries out of the sum.
                b = ($urandom_range(3) == 0) ? 8'hFF : BYTE_W'($urandom);
                send_byte(t_cmd'($urandom_range(3)), b, $urandom, k == len - 1);
            end
        end
    endtask

    task automatic drain_and_settle();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        i_s_tlast  = 1'b0;
        while (sb.expected_sums.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_local_ip(logic [IP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.local_ip = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = CMD_IP;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        idle_on     = 1;
        hold_rx     = 0;
        bytes_sent  = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed packets with an all-ones local address so that every
        // pseudo-header word carries.
        write_local_ip(32'hFFFF_FFFF);
        send_frame(CMD_IP,   32'h0000_0000, 1, 64'hFF00_0000_0000_0000);
        send_frame(CMD_UDP,  32'h0000_0000, 2, 64'h0000_0000_0000_0000);
        send_frame(CMD_TCP,  32'hFFFF_FFFF, 3, 64'hFFFF_FF00_0000_0000);
        send_frame(CMD_RSVD, 32'hA5A5_A5A5, 4, 64'h1234_5678_0000_0000);
        send_frame(CMD_UDP,  32'h5A5A_5A5A, 5, 64'h8001_7FFE_5500_0000);
        send_frame(CMD_TCP,  32'h0000_FFFF, 6, 64'hFFFF_0000_FFFF_0000);
        drain_and_settle();

        write_local_ip(32'h0000_0000);
        send_random_packets(150, 1, 40);
        drain_and_settle();

        // Long stretch with no gaps on either side.
        idle_on = 0;
        write_local_ip($urandom);
        send_random_packets(120, 1, 40);
        drain_and_settle();
        idle_on = 1;

        // Receiver holds off while short packets keep coming, so the block
        // backs up and drops its tready.
        write_local_ip(32'hC0A8_0001);
        fork
            begin
                hold_rx = 1;
                repeat (300) @(posedge i_clk);
                hold_rx = 0;
            end
        join_none
        send_random_packets(80, 1, 3);
        drain_and_settle();

        // One overlong packet: bytes past the limit, the last one among them,
        // are dropped from the sum while tlast still closes the packet.
        write_local_ip($urandom);
        for (int k = 0; k < PKT_LIMIT + 3; k++)
            send_byte(($urandom_range(1) == 0) ? CMD_UDP : CMD_TCP, BYTE_W'($urandom),
                      $urandom, k == PKT_LIMIT + 2);
        send_random_packets(200, 1, 40);
        drain_and_settle();
        repeat (10) @(posedge i_clk);

        if (sb.expected_sums.size() != 0)
            sb.report($sformatf("%0d checksums never returned", sb.expected_sums.size()));
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/icsum_pkg.sv
rtl/core/internet_checksum_pseudo_header_top.sv
verif/tb_top.sv
